// ----- hw/rtl/b2d_pkg.sv -----
// Package: shared widths and the BCD digit correction for the binary-to-decimal converter.
`timescale 1ns / 1ps

package b2d_pkg;

  // Width of one BCD digit and of the digit count on the result channel.
  localparam int DIGIT_W = 4;
  localparam int COUNT_W = 4;

  // Digit correction before each shift: add 3 to any digit of 5 or more.
  function automatic logic [DIGIT_W-1:0] add3(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    r = d;
    if (d >= DIGIT_W'(5)) begin
      r = d + DIGIT_W'(3);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/binary_to_decimal_digits.sv -----
// Top level: splits a binary value into its decimal digits by shift-add-3 conversion.
// Sequence: shift-add-3 conversion (one shared digit-correction step per cycle), then leading
//   zeros are stripped, then a digit a cycle whenever digit_stall is low.
// A new request is taken only once the last digit of the previous one has left;
//   value_stall is high from acceptance until the last digit leaves.
// Reset (rst, synchronous, active high) returns the sequencer to idle with no digit pending.
`timescale 1ns / 1ps

module binary_to_decimal_digits #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          value_valid,
  output logic                          value_stall,
  input  logic [VALUE_BITS-1:0]         value,
  output logic                          digit_valid,
  input  logic                          digit_stall,
  output logic [b2d_pkg::DIGIT_W-1:0]   digit,
  output logic [b2d_pkg::COUNT_W-1:0]   digit_count,
  output logic                          last
);

  localparam int BCD_W   = MAX_DIGITS * b2d_pkg::DIGIT_W;
  localparam int STEP_W  = $clog2(VALUE_BITS + 1);
  localparam int CNT_W   = $clog2(MAX_DIGITS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONVERT,
    S_STRIP,
    S_EMIT
  } state_t;

  state_t              state;
  logic [VALUE_BITS-1:0] binary_shift;
  logic [BCD_W-1:0]    bcd_digits;
  logic [STEP_W-1:0]   step_count;
  logic [CNT_W-1:0]    count_held;
  logic [CNT_W-1:0]    remaining;

  logic [BCD_W-1:0]    bcd_adjusted;
  logic [BCD_W-1:0]    bcd_next;
  logic [b2d_pkg::DIGIT_W-1:0] top_digit;
  logic                value_take;
  logic                digit_take;

  // Shared step: correct every digit lane, then shift in the next binary bit
  always_comb begin
    for (int d = 0; d < MAX_DIGITS; d++) begin
      bcd_adjusted[d*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W] =
        b2d_pkg::add3(bcd_digits[d*b2d_pkg::DIGIT_W +: b2d_pkg::DIGIT_W]);
    end
    bcd_next = {bcd_adjusted[BCD_W-2:0], binary_shift[VALUE_BITS-1]};
  end

  assign top_digit  = bcd_digits[BCD_W-1 -: b2d_pkg::DIGIT_W];
  assign value_take = value_valid && !value_stall;
  assign digit_take = digit_valid && !digit_stall;

  // Handshake and result fields straight from registers
  assign value_stall = (state != S_IDLE);
  assign digit_valid = (state == S_EMIT);
  assign digit       = top_digit;
  assign digit_count = b2d_pkg::COUNT_W'(count_held);
  assign last        = (remaining == CNT_W'(1));

  // Sequencer: convert, strip leading zeros, emit digits
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      binary_shift <= '0;
      bcd_digits   <= '0;
      step_count   <= '0;
      count_held   <= '0;
      remaining    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (value_take) begin
            binary_shift <= value;
            bcd_digits   <= '0;
            step_count   <= STEP_W'(VALUE_BITS - 1);
            state        <= S_CONVERT;
          end
        end
        S_CONVERT: begin
          bcd_digits   <= bcd_next;
          binary_shift <= {binary_shift[VALUE_BITS-2:0], 1'b0};
          step_count   <= step_count - STEP_W'(1);
          if (step_count == '0) begin
            count_held <= CNT_W'(MAX_DIGITS);
            state      <= S_STRIP;
          end
        end
        S_STRIP: begin
          // drop one leading zero a cycle; a lone zero digit is kept
          if (count_held > CNT_W'(1) && top_digit == '0) begin
            bcd_digits <= {bcd_digits[BCD_W-b2d_pkg::DIGIT_W-1:0],
                           {b2d_pkg::DIGIT_W{1'b0}}};
            count_held <= count_held - CNT_W'(1);
          end else begin
            remaining <= count_held;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (digit_take) begin
            bcd_digits <= {bcd_digits[BCD_W-b2d_pkg::DIGIT_W-1:0],
                           {b2d_pkg::DIGIT_W{1'b0}}};
            remaining  <= remaining - CNT_W'(1);
            if (remaining == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // No new request is taken while digits are still going out
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> value_stall)
    else $error("request accepted while digits pending");

  // An accepted request always starts a conversion
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    value_take |=> (value_stall && !digit_valid))
    else $error("converter not busy after request");

  // The final digit taken ends the run
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (digit_take && last) |=> (!digit_valid && !value_stall))
    else $error("run continues after last digit");

  // Every emitted digit is a decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    digit_valid |-> (digit <= b2d_pkg::DIGIT_W'(9)))
    else $error("digit out of decimal range");

  // The run never starts with a zero unless it is the single digit of zero
  a_no_leading_zero: assert property (@(posedge clk) disable iff (rst)
    (digit_valid && !$past(digit_valid)) |-> (digit != '0 || last))
    else $error("leading zero emitted");

endmodule

// ----- dv/tb_binary_to_decimal_digits.sv -----
// Testbench: directed table plus random values checked digit by digit against a shift-add-3 predictor.
`timescale 1ns / 1ps

module tb_binary_to_decimal_digits;

  localparam int DIGIT_W = b2d_pkg::DIGIT_W;
  localparam int COUNT_W = b2d_pkg::COUNT_W;

  localparam int VALUE_W = 31;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W = NUM_DIGITS * DIGIT_W;
  localparam longint MAX_VALUE = 64'h7FFF_FFFF;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 450;
  localparam int DRAIN_CYCLES = 60;
  localparam int IDLE_LIMIT = 4000;
  localparam int PRINT_LIMIT = 50;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [COUNT_W-1:0] count;
    logic               last;
  } digit_result_t;

  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [COUNT_W-1:0] count;
  } decimal_split_t;

  typedef struct packed {
    logic [VALUE_W-1:0] val;
    logic               typed;
    logic [BCD_W-1:0]   bcd;
    logic [COUNT_W-1:0] count;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic value_valid = 1'b0;
  logic value_stall;
  logic [VALUE_W-1:0] value = '0;
  logic digit_valid;
  logic digit_stall = 1'b0;
  logic [DIGIT_W-1:0] digit;
  logic [COUNT_W-1:0] digit_count;
  logic last;

  digit_result_t pending_digits[$];
  int mismatches = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  logic [15:0] stall_pattern = '0;
  logic [5:0] stall_phase = '0;

  // Extremes and the one, two, nine and ten digit cases have their digits typed in; the rest use the predictor
  directed_row_t directed_rows [22] = '{
    '{31'd0,          1'b1, 40'h00_0000_0000, 4'd1},
    '{31'd1,          1'b1, 40'h00_0000_0001, 4'd1},
    '{31'd9,          1'b1, 40'h00_0000_0009, 4'd1},
    '{31'd10,         1'b1, 40'h00_0000_0010, 4'd2},
    '{31'd2147483647, 1'b1, 40'h21_4748_3647, 4'd10},
    '{31'd1000000000, 1'b1, 40'h10_0000_0000, 4'd10},
    '{31'd999999999,  1'b1, 40'h09_9999_9999, 4'd9},
    '{31'd5,          1'b0, '0, '0},
    '{31'd8,          1'b0, '0, '0},
    '{31'd19,         1'b0, '0, '0},
    '{31'd50,         1'b0, '0, '0},
    '{31'd99,         1'b0, '0, '0},
    '{31'd100,        1'b0, '0, '0},
    '{31'd4999,       1'b0, '0, '0},
    '{31'd65536,      1'b0, '0, '0},
    '{31'd1073741824, 1'b0, '0, '0},
    '{31'h2AAA_AAAA,  1'b0, '0, '0},
    '{31'h5555_5555,  1'b0, '0, '0},
    '{31'd1234567890, 1'b0, '0, '0},
    '{31'd59595959,   1'b0, '0, '0},
    '{31'h7FFF_FFFE,  1'b0, '0, '0},
    '{31'd100000000,  1'b0, '0, '0}
  };

  binary_to_decimal_digits #(
    .VALUE_BITS(VALUE_W),
    .MAX_DIGITS(NUM_DIGITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .value_valid(value_valid),
    .value_stall(value_stall),
    .value(value),
    .digit_valid(digit_valid),
    .digit_stall(digit_stall),
    .digit(digit),
    .digit_count(digit_count),
    .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shift-add-3: correct each nibble of 5 or more, then shift one value bit in
  function automatic decimal_split_t split_decimal(input logic [VALUE_W-1:0] v);
    logic [BCD_W-1:0] bcd;
    logic [VALUE_W-1:0] shifter;
    decimal_split_t r;
    int s;
    int d;
    bcd = '0;
    shifter = v;
    for (s = 0; s < VALUE_W; s++) begin
      for (d = 0; d < NUM_DIGITS; d++) begin
        if (bcd[DIGIT_W*d +: DIGIT_W] >= 4'd5) begin
          bcd[DIGIT_W*d +: DIGIT_W] = bcd[DIGIT_W*d +: DIGIT_W] + 4'd3;
        end
      end
      bcd = {bcd[BCD_W-2:0], shifter[VALUE_W-1]};
      shifter = shifter << 1;
    end
    r.bcd = bcd;
    r.count = 4'd1;
    // Digit count from the highest non-zero digit; zero still has one digit
    for (d = NUM_DIGITS - 1; d >= 1; d--) begin
      if (bcd[DIGIT_W*d +: DIGIT_W] != '0 && r.count == 4'd1) begin
        r.count = COUNT_W'(d + 1);
      end
    end
    return r;
  endfunction

  // Expected digits of one request, most significant first
  task automatic queue_digits(input logic [BCD_W-1:0] bcd, input logic [COUNT_W-1:0] count);
    digit_result_t item;
    int i;
    for (i = int'(count) - 1; i >= 0; i--) begin
      item.digit = bcd[DIGIT_W*i +: DIGIT_W];
      item.count = count;
      item.last = (i == 0);
      pending_digits.push_back(item);
    end
  endtask

  function automatic longint ten_pow(input int k);
    longint p;
    int i;
    p = 1;
    for (i = 0; i < k; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  // Random values: full range, a chosen digit count, near powers of ten, digits rich in 0, 4, 5 and 9
  function automatic logic [VALUE_W-1:0] pick_random_value();
    longint lo;
    longint hi;
    longint acc;
    int n;
    int i;
    case ($urandom_range(0, 3))
      0: begin
        acc = longint'(VALUE_W'($urandom()));
      end
      1: begin
        n = $urandom_range(1, NUM_DIGITS);
        lo = (n == 1) ? 0 : ten_pow(n - 1);
        hi = ten_pow(n) - 1;
        if (hi > MAX_VALUE) begin
          hi = MAX_VALUE;
        end
        acc = longint'($urandom_range(32'(hi), 32'(lo)));
      end
      2: begin
        acc = ten_pow($urandom_range(0, NUM_DIGITS - 1)) + $urandom_range(0, 6) - 3;
        if (acc < 0) begin
          acc = 0;
        end
      end
      default: begin
        n = $urandom_range(1, NUM_DIGITS);
        acc = (n == NUM_DIGITS) ? 1 : $urandom_range(1, 9);
        for (i = 1; i < n; i++) begin
          case ($urandom_range(0, 4))
            0: acc = acc * 10;
            1: acc = acc * 10 + 4;
            2: acc = acc * 10 + 5;
            3: acc = acc * 10 + 9;
            default: acc = acc * 10 + $urandom_range(0, 9);
          endcase
        end
      end
    endcase
    if (acc > MAX_VALUE) begin
      acc = MAX_VALUE;
    end
    return VALUE_W'(acc);
  endfunction

  // Sender: bursts of back-to-back requests separated by random gaps
  task automatic offer_value(input logic [VALUE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      value_valid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 50) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    value_valid <= 1'b1;
    value <= v;
    @(posedge clk);
    while (value_stall) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (mismatches < PRINT_LIMIT) begin
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    end
    mismatches++;
  endtask

  // Receiver stall: a fresh 16-bit pattern each time stall_phase wraps, sometimes none at all
  always @(posedge clk) begin
    if (stall_phase == '0) begin
      case ($urandom_range(0, 3))
        0: stall_pattern = '0;
        1: stall_pattern = 16'($urandom());
        2: stall_pattern = 16'($urandom() & $urandom());
        default: stall_pattern = 16'($urandom() | $urandom());
      endcase
      stall_pattern[$urandom_range(0, 15)] = 1'b0;
    end
    digit_stall <= stall_pattern[stall_phase[3:0]];
    stall_phase <= stall_phase + 6'd1;
  end

  // Compare each accepted digit with the oldest expectation
  always @(posedge clk) begin
    digit_result_t want;
    if (!rst && digit_valid && !digit_stall) begin
      if (pending_digits.size() == 0) begin
        report_mismatch("digit with none pending", 0, digit);
      end else begin
        want = pending_digits.pop_front();
        if (digit !== want.digit) report_mismatch("digit", want.digit, digit);
        if (digit_count !== want.count) report_mismatch("digit_count", want.count, digit_count);
        if (last !== want.last) report_mismatch("last", want.last, last);
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (value_valid && !value_stall) || (digit_valid && !digit_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    decimal_split_t split;
    logic [VALUE_W-1:0] v;
    int n;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (directed_rows[r]) begin
      offer_value(directed_rows[r].val);
      if (directed_rows[r].typed) begin
        queue_digits(directed_rows[r].bcd, directed_rows[r].count);
      end else begin
        split = split_decimal(directed_rows[r].val);
        queue_digits(split.bcd, split.count);
      end
    end

    // Random requests
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      v = pick_random_value();
      offer_value(v);
      split = split_decimal(v);
      queue_digits(split.bcd, split.count);
    end
    value_valid <= 1'b0;

    while (pending_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
